### rtl/core/mse_pkg.sv
// Shared constants and types for the merge sort engine.
package mse_pkg;

	// Default number of entries in the element store.
	localparam int MSE_CAPACITY = 32;

	// Width of one element.
	localparam int DATA_W = 32;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_LOAD    = 6'b000001,
		ST_SEG     = 6'b000010,
		ST_RD      = 6'b000100,
		ST_CMP     = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_WR = 6'b100000
	} mse_state_t;

endpackage

### rtl/core/mse_ram.sv
// Element bank: one write port and two read ports with registered read data.
module mse_ram #(
	parameter int DEPTH = mse_pkg::MSE_CAPACITY,
	parameter int AW    = $clog2(mse_pkg::MSE_CAPACITY)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [mse_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]              raddr_a,
	input  logic [AW-1:0]              raddr_b,
	output logic [mse_pkg::DATA_W-1:0] rdata_a,
	output logic [mse_pkg::DATA_W-1:0] rdata_b
);
	import mse_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### rtl/core/merge_sort_engine.sv
// Merge sort engine top level: element load, bottom-up merge sequencer and result output.
//
// The block takes one word per cycle while loading; a word with last set, or the word
// that fills the store of CAPACITY entries, closes the set, and no word is taken until
// every sorted result of that set has been placed in the output register. A set of n
// elements is sorted by ceil(log2(n)) merge passes that ping-pong between two banks;
// every element written in a pass goes through a registered bank read (ST_RD) and then
// the single shared comparator (ST_CMP), and each run pair adds a setup state (ST_SEG).
// Output reads each result through the same read port (port A), in ST_EMIT_RD and then
// ST_EMIT_WR; results wait in an output register, so the block goes back to loading as
// soon as the last one is placed.
module merge_sort_engine #(
	parameter int CAPACITY = mse_pkg::MSE_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [mse_pkg::DATA_W-1:0] value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mse_pkg::DATA_W-1:0] sorted_value,
	output logic                              final_res
);
	import mse_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int SW = CW + 2;
	localparam logic [CW-1:0] LAST_IDX = CW'(CAPACITY - 1);

	mse_state_t        state_q;
	logic [CW-1:0]     count_q;
	logic [SW-1:0]     n_q;
	logic [SW-1:0]     w_q;
	logic [SW-1:0]     lo_q;
	logic [SW-1:0]     mid_q;
	logic [SW-1:0]     hi_q;
	logic [SW-1:0]     l_q;
	logic [SW-1:0]     r_q;
	logic [SW-1:0]     o_q;
	logic [SW-1:0]     k_q;
	logic              src_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] sorted_value_q;
	logic              final_res_q;

	logic [SW-1:0]     lo_w;
	logic [SW-1:0]     lo_2w;
	logic [SW-1:0]     mid_c;
	logic [SW-1:0]     hi_c;
	logic [DATA_W-1:0] a_data;
	logic [DATA_W-1:0] b_data;
	logic [DATA_W-1:0] b0_a;
	logic [DATA_W-1:0] b0_b;
	logic [DATA_W-1:0] b1_a;
	logic [DATA_W-1:0] b1_b;
	logic              take_left;
	logic [DATA_W-1:0] merge_data;
	logic              b0_we;
	logic              b1_we;
	logic [AW-1:0]     b0_waddr;
	logic [DATA_W-1:0] b0_wdata;
	logic [AW-1:0]     raddr_a;
	logic [AW-1:0]     raddr_b;
	logic              out_free;
	logic              emit_last;
	logic              emit_load;

	// Bounds of the next run pair, clamped to the set size.
	assign lo_w  = lo_q + w_q;
	assign lo_2w = lo_q + (w_q << 1);
	assign mid_c = (lo_w > n_q) ? n_q : lo_w;
	assign hi_c  = (lo_2w > n_q) ? n_q : lo_2w;

	// The source bank of the current pass feeds the comparator.
	assign a_data = src_q ? b1_a : b0_a;
	assign b_data = src_q ? b1_b : b0_b;

	// Left run wins ties so the merge stays stable.
	assign take_left = (l_q < mid_q) &&
		((r_q >= hi_q) || ($signed(a_data) <= $signed(b_data)));
	assign merge_data = take_left ? a_data : b_data;

	// Bank 0 takes loaded words and merge output of even passes; bank 1 of odd passes (first is 1).
	assign b0_we    = ((state_q == ST_LOAD) && in_valid) || ((state_q == ST_CMP) && src_q);
	assign b0_waddr = (state_q == ST_LOAD) ? count_q[AW-1:0] : o_q[AW-1:0];
	assign b0_wdata = (state_q == ST_LOAD) ? value : merge_data;
	assign b1_we    = (state_q == ST_CMP) && !src_q;

	// Port A serves the left run while merging and the output index while emitting.
	assign raddr_a = ((state_q == ST_EMIT_RD) || (state_q == ST_EMIT_WR)) ?
		k_q[AW-1:0] : l_q[AW-1:0];
	assign raddr_b = r_q[AW-1:0];

	mse_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_bank0 (
		.clk     (clk),
		.we      (b0_we),
		.waddr   (b0_waddr),
		.wdata   (b0_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (b0_a),
		.rdata_b (b0_b)
	);

	mse_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_bank1 (
		.clk     (clk),
		.we      (b1_we),
		.waddr   (o_q[AW-1:0]),
		.wdata   (merge_data),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (b1_a),
		.rdata_b (b1_b)
	);

	// Output register hand-off.
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_last = (k_q + SW'(1)) == n_q;
	assign emit_load = (state_q == ST_EMIT_WR) && out_free;

	// Sequencer: load, merge passes, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			n_q     <= '0;
			w_q     <= SW'(1);
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			l_q     <= '0;
			r_q     <= '0;
			o_q     <= '0;
			k_q     <= '0;
			src_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (last || (count_q == LAST_IDX)) begin
							n_q     <= SW'(count_q) + SW'(1);
							count_q <= '0;
							w_q     <= SW'(1);
							lo_q    <= '0;
							src_q   <= 1'b0;
							state_q <= ST_SEG;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_SEG: begin
					if (w_q >= n_q) begin
						k_q     <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						mid_q   <= mid_c;
						hi_q    <= hi_c;
						l_q     <= lo_q;
						r_q     <= mid_c;
						o_q     <= lo_q;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					o_q <= o_q + SW'(1);
					if (take_left) begin
						l_q <= l_q + SW'(1);
					end else begin
						r_q <= r_q + SW'(1);
					end
					if ((o_q + SW'(1)) == hi_q) begin
						if (lo_2w >= n_q) begin
							w_q   <= w_q << 1;
							src_q <= !src_q;
							lo_q  <= '0;
						end else begin
							lo_q <= lo_2w;
						end
						state_q <= ST_SEG;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						k_q     <= k_q + SW'(1);
						state_q <= emit_last ? ST_LOAD : ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit_load) begin
			sorted_value_q <= a_data;
			final_res_q    <= emit_last;
		end
	end

	assign in_stall     = (state_q != ST_LOAD);
	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign final_res    = final_res_q;

endmodule

### sim/merge_sort_engine_tb.sv
// Self-checking testbench for the merge sort engine: directed and random sets against a sort predictor.
module merge_sort_engine_tb;

	localparam int STORE_DEPTH = mse_pkg::MSE_CAPACITY;
	localparam int RANDOM_WORDS = 420;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 200;

	typedef logic signed [mse_pkg::DATA_W-1:0] elem_t;

	// One sorted word as it should leave the block.
	typedef struct packed {
		elem_t val;
		logic  fin;
	} sorted_word_t;

	// One row of the directed stimulus; typed rows carry their own expected word.
	typedef struct {
		elem_t v;
		logic  l;
		bit    typed;
		elem_t exp_v;
		logic  exp_f;
	} stim_row_t;

	localparam int DIR_ROWS = 22;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	elem_t value;
	logic  last;
	logic  out_valid;
	logic  out_stall;
	elem_t sorted_value;
	logic  final_res;

	elem_t        open_set[$];
	sorted_word_t sorted_due[$];
	int           fault_count = 0;
	bit           quiet = 1'b0;
	bit           hold_req = 1'b0;

	stim_row_t dir_rows [DIR_ROWS] = '{
		// Single-word sets come back unchanged and marked final.
		'{32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff, 1'b1},
		'{32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b1},
		'{32'sh00000000, 1'b1, 1'b1, 32'sh00000000, 1'b1},
		'{32'shffffffff, 1'b1, 1'b1, 32'shffffffff, 1'b1},
		// Ties, both extremes and signed order in one set.
		'{32'sh00000005, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'shfffffffd, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'sh00000005, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'sh80000000, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'sh7fffffff, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'shfffffffd, 1'b1, 1'b0, 32'sh0, 1'b0},
		// Two equal words.
		'{32'sh00000007, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'sh00000007, 1'b1, 1'b0, 32'sh0, 1'b0},
		// Descending input.
		'{32'sh00000003, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'sh00000002, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'sh00000001, 1'b1, 1'b0, 32'sh0, 1'b0},
		// Values whose unsigned order differs from their signed order.
		'{32'sh40000000, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'shc0000000, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'sh00000001, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'shfffffffe, 1'b1, 1'b0, 32'sh0, 1'b0},
		// Already ascending input.
		'{32'shfffffffe, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'shffffffff, 1'b0, 1'b0, 32'sh0, 1'b0},
		'{32'sh00000000, 1'b1, 1'b0, 32'sh0, 1'b0}
	};

	merge_sort_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sorted_value(sorted_value),
		.final_res   (final_res)
	);

	// Clock with a period of 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Print one line per mismatch and count it.
	task automatic report_fault(input string msg);
		if (fault_count < MAX_REPORTS)
			$display("ERROR at %0t: %s", $time, msg);
		fault_count++;
	endtask

	// Stable bottom-up merge sort of the open set; queue its words as expected output.
	function automatic void sort_open_set();
		elem_t keys [STORE_DEPTH];
		elem_t merged [STORE_DEPTH];
		int n, w, lo, mid, hi, a, b, o;
		n = open_set.size();
		for (o = 0; o < n; o++)
			keys[o] = open_set[o];
		for (w = 1; w < n; w = w * 2) begin
			for (lo = 0; lo < n; lo = lo + 2 * w) begin
				mid = (lo + w < n) ? lo + w : n;
				hi = (lo + 2 * w < n) ? lo + 2 * w : n;
				a = lo;
				b = mid;
				// On a tie the left run goes first.
				for (o = lo; o < hi; o++) begin
					if (b >= hi || (a < mid && keys[a] <= keys[b])) begin
						merged[o] = keys[a];
						a++;
					end else begin
						merged[o] = keys[b];
						b++;
					end
				end
			end
			for (o = 0; o < n; o++)
				keys[o] = merged[o];
		end
		for (o = 0; o < n; o++)
			sorted_due.push_back('{keys[o], (o == n - 1)});
		open_set.delete();
	endfunction

	// Track the set being loaded; a last word or a full store closes it.
	function automatic void predict_word(input elem_t v, input logic l);
		open_set.push_back(v);
		if (l || open_set.size() == STORE_DEPTH)
			sort_open_set();
	endfunction

	// Offer one word, with random idle cycles ahead of it, and wait until it is taken.
	task automatic send_word(input elem_t v, input logic l);
		while (!quiet && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= l;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Mostly full-range values, with small values for ties and the extremes.
	function automatic elem_t pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return elem_t'($urandom);
		if (sel < 8)
			return elem_t'($urandom_range(0, 8)) - 4;
		if (sel == 8) begin
			case ($urandom_range(0, 3))
				0: return 32'sh80000000;
				1: return 32'sh7fffffff;
				2: return 32'sh0;
				default: return 32'shffffffff;
			endcase
		end
		return elem_t'($urandom & 32'h8000000f);
	endfunction

	// Receiver: random stalls, one long hold-off on request, none while quiet.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_req && !held) begin
				hold_left = HOLD_CYCLES;
				held = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 24);
			end
		end
	end

	// Compare every accepted output word with the oldest expected one.
	always @(posedge clk) begin
		sorted_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sorted_due.size() == 0) begin
				report_fault($sformatf("unexpected word %0d final %0b", sorted_value, final_res));
			end else begin
				want = sorted_due.pop_front();
				if (sorted_value !== want.val)
					report_fault($sformatf("sorted_value %0d, expected %0d",
						sorted_value, want.val));
				if (final_res !== want.fin)
					report_fault($sformatf("final_res %0b, expected %0b on value %0d",
						final_res, want.fin, want.val));
			end
		end
	end

	// Stimulus: reset, directed table, then random sets.
	initial begin
		int k, set_len, words_sent, pick;
		elem_t v;
		logic l;
		bit first_set;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value <= '0;
		last <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows.
		for (k = 0; k < DIR_ROWS; k++) begin
			send_word(dir_rows[k].v, dir_rows[k].l);
			if (dir_rows[k].typed)
				sorted_due.push_back('{dir_rows[k].exp_v, dir_rows[k].exp_f});
			else
				predict_word(dir_rows[k].v, dir_rows[k].l);
		end

		// Random sets; the first one fills the store with no last flag.
		words_sent = 0;
		first_set = 1'b1;
		while (words_sent < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (first_set || pick < 12)
				set_len = STORE_DEPTH;
			else if (pick < 25)
				set_len = $urandom_range(9, STORE_DEPTH - 1);
			else
				set_len = $urandom_range(1, 8);
			for (k = 0; k < set_len; k++) begin
				quiet = (words_sent >= 220 && words_sent < 300);
				if (words_sent == 120)
					hold_req = 1'b1;
				v = pick_value();
				if (k != set_len - 1)
					l = 1'b0;
				else if (set_len == STORE_DEPTH)
					l = first_set ? 1'b0 : 1'($urandom_range(0, 1));
				else
					l = 1'b1;
				send_word(v, l);
				predict_word(v, l);
				words_sent++;
			end
			first_set = 1'b0;
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		// Drain the outstanding results, then allow a few more cycles.
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("merge_sort_engine_tb OK");
		else
			$display("merge_sort_engine_tb NOT OK");
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#2000000;
		$display("merge_sort_engine_tb NOT OK");
		$finish;
	end

endmodule

### merge_sort_engine.f
rtl/core/mse_pkg.sv
rtl/core/mse_ram.sv
rtl/core/merge_sort_engine.sv
sim/merge_sort_engine_tb.sv
